// File: hdl/assert_macros.svh
// assertion helpers used by the rtl file ordered_key_list_engine.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OKL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OKL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/okl_pkg.sv
package okl_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int TOTAL_W   = 5;

  localparam logic [1:0] FN_APPEND = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_SEARCH = 2'd2;
  localparam logic [1:0] FN_POP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MARK,
    OP_LOAD,
    OP_POP,
    OP_COMPACT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   link;
  } okl_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   link;
    logic               valid;
    logic               mark;
  } okl_entry_t;

endpackage

// File: hdl/okl_cell.sv
module okl_cell
  import okl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  okl_cmd_t   cmd,
  input  okl_entry_t nb,
  input  logic       prev_valid,
  input  logic       mark_in,
  output okl_entry_t ent,
  output logic       mark_out
);

  // any matched entry at or ahead of this cell
  assign mark_out = mark_in | ent.mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      ent.mark  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_MARK: begin
          ent.mark <= ent.valid && (ent.key == cmd.key);
        end
        OP_LOAD: begin
          if (!ent.valid && prev_valid) begin
            ent.key   <= cmd.key;
            ent.link  <= cmd.link;
            ent.valid <= 1'b1;
            ent.mark  <= 1'b0;
          end
        end
        OP_POP: begin
          ent <= nb;
        end
        OP_COMPACT: begin
          if (mark_out) begin
            ent <= nb;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/ordered_key_list_engine.sv
// channel  | direction | handshake            | word
// ---------+-----------+----------------------+----------------------------------
// request  | in        | req_valid/req_stall  | func, key_value, link_value
// response | out       | rsp_valid/rsp_stall  | found, status, entry_total
//
// append, search and pop go from accept to the finish state, which loads the
// response register once it is free; remove on a non-empty list first passes the
// compact state, which closes up one matching entry per cycle until no mark is left
// rst clears the count, the cell valid and mark bits and the response valid
// a stalled response holds its word; the next request is taken once it is loaded
`include "assert_macros.svh"

module ordered_key_list_engine
  import okl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           func,
  input  logic signed [31:0]   key_value,
  input  logic signed [31:0]   link_value,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic                 found,
  output logic [1:0]           status,
  output logic [TOTAL_W-1:0]   entry_total
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_COMPACT = 3'b010,
    S_FINISH  = 3'b100
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic                pend_found;
  logic [1:0]          pend_status;
  logic                pend_search;

  okl_cmd_t            cmd;
  okl_entry_t          ent   [DEPTH];
  okl_entry_t          nb    [DEPTH];
  logic [DEPTH:0]      mark_chain;
  logic [DEPTH-1:0]    valid_chain;
  logic [DEPTH-1:0]    valid_vec;
  logic                any_mark;
  logic                accept;
  logic                rsp_free;
  logic                is_full;
  logic                is_empty;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign any_mark  = mark_chain[DEPTH];

  assign mark_chain[0]  = 1'b0;
  assign valid_chain[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign nb[i] = '0;
    end else begin : g_mid
      assign nb[i]            = ent[i+1];
      assign valid_chain[i+1] = ent[i].valid;
    end
    assign valid_vec[i] = ent[i].valid;

    okl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .nb         (nb[i]),
      .prev_valid (valid_chain[i]),
      .mark_in    (mark_chain[i]),
      .ent        (ent[i]),
      .mark_out   (mark_chain[i+1])
    );
  end

  always_comb begin
    cmd.op   = OP_HOLD;
    cmd.key  = key_value;
    cmd.link = link_value;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FN_APPEND: cmd.op = is_full ? OP_HOLD : OP_LOAD;
            FN_POP:    cmd.op = is_empty ? OP_HOLD : OP_POP;
            default:   cmd.op = is_empty ? OP_HOLD : OP_MARK;
          endcase
        end
      end
      S_COMPACT: cmd.op = any_mark ? OP_COMPACT : OP_HOLD;
      S_FINISH:  cmd.op = OP_HOLD;
      default:   cmd.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_found  <= 1'b0;
            pend_search <= (func == FN_SEARCH) && !is_empty;
            if (func == FN_APPEND) begin
              pend_status <= is_full ? ST_FULL : ST_OK;
              state       <= S_FINISH;
              if (!is_full) begin
                count <= count + 1'b1;
              end
            end else if (is_empty) begin
              pend_status <= ST_EMPTY;
              state       <= S_FINISH;
            end else begin
              pend_status <= ST_OK;
              state       <= (func == FN_REMOVE) ? S_COMPACT : S_FINISH;
              if (func == FN_POP) begin
                count <= count - 1'b1;
              end
            end
          end
        end
        S_COMPACT: begin
          if (any_mark) begin
            count      <= count - 1'b1;
            pend_found <= 1'b1;
          end else begin
            pend_status <= pend_found ? ST_OK : ST_NOTFOUND;
            state       <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && rsp_free) begin
      found       <= pend_search ? any_mark : pend_found;
      status      <= pend_search ? (any_mark ? ST_OK : ST_NOTFOUND) : pend_status;
      entry_total <= TOTAL_W'(count);
    end
  end

  `OKL_ASSERT_NOW(a_count_matches_cells, clk, rst, 1'b1, $countones(valid_vec) == int'(count), "valid cells differ from count")
  `OKL_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != S_IDLE, "request accepted but controller idle")
  `OKL_ASSERT_NEXT(a_compact_shrinks, clk, rst, state == S_COMPACT && any_mark, count == CW'($past(count) - 1'b1), "compaction step did not drop one entry")
  `OKL_ASSERT_NOW(a_count_bounded, clk, rst, 1'b1, count <= CW'(DEPTH), "count above depth")

endmodule

// File: tb/ordered_key_list_engine_test.sv
module ordered_key_list_engine_test;
  import okl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_WORDS = 1630;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] link;
    bit          drain_first;
    int          gap_after;
  } request_t;

  typedef struct {
    logic                found;
    logic [1:0]          status;
    logic [TOTAL_W-1:0]  total;
  } reply_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  logic [1:0]                 func = FN_SEARCH;
  logic signed [31:0]         key_value = '0;
  logic signed [31:0]         link_value = '0;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  logic                       found;
  logic [1:0]                 status;
  logic [TOTAL_W-1:0]         entry_total;

  request_t    request_queue[$];
  reply_t      expected_replies[$];
  logic [31:0] list_keys[DEPTH_DEF];
  logic [31:0] list_links[DEPTH_DEF];
  int          list_count = 0;

  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;
  int   send_gap = 0;
  int   rx_wait = 0;
  bit   rx_burst = 0;
  bit   tx_burst = 0;
  int   replies_seen = 0;
  int   idle_cycles = 0;
  int   fail_count = 0;

  ordered_key_list_engine #(.DEPTH(DEPTH_DEF)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .func(func),
    .key_value(key_value),
    .link_value(link_value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .found(found),
    .status(status),
    .entry_total(entry_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic reply_t list_apply(input logic [1:0] op, input logic [31:0] key,
                                        input logic [31:0] link);
    reply_t r;
    int     kept;
    bit     hit;
    r.found = 1'b0;
    r.status = ST_OK;
    if (op == FN_APPEND) begin
      if (list_count >= DEPTH_DEF) begin
        r.status = ST_FULL;
      end else begin
        list_keys[list_count] = key;
        list_links[list_count] = link;
        list_count++;
      end
    end else if (list_count == 0) begin
      r.status = ST_EMPTY;
    end else if (op == FN_POP) begin
      for (int i = 1; i < list_count; i++) begin
        list_keys[i-1] = list_keys[i];
        list_links[i-1] = list_links[i];
      end
      list_count--;
    end else if (op == FN_SEARCH) begin
      hit = 0;
      for (int i = 0; i < list_count; i++)
        if (list_keys[i] == key) hit = 1;
      r.found = hit;
      r.status = hit ? ST_OK : ST_NOTFOUND;
    end else begin
      kept = 0;
      for (int i = 0; i < list_count; i++) begin
        if (list_keys[i] != key) begin
          list_keys[kept] = list_keys[i];
          list_links[kept] = list_links[i];
          kept++;
        end
      end
      hit = (kept != list_count);
      list_count = kept;
      r.found = hit;
      r.status = hit ? ST_OK : ST_NOTFOUND;
    end
    r.total = list_count[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic queue_word(input logic [1:0] op, input logic [31:0] key,
                            input logic [31:0] link, input bit drain);
    request_t w;
    w.op = op;
    w.key = key;
    w.link = link;
    w.drain_first = drain;
    w.gap_after = tx_burst ? 0 : $urandom_range(0, 13);
    request_queue.push_back(w);
  endtask

  // sender: one word at a time, gap drawn per word
  always @(negedge clk) begin : drive_requests
    request_t w;
    if (!rst && !(req_valid && !req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (request_queue.size() > 0 &&
                   !(request_queue[0].drain_first && expected_replies.size() > 0)) begin
        w = request_queue.pop_front();
        func <= w.op;
        key_value <= w.key;
        link_value <= w.link;
        req_valid <= 1'b1;
        send_gap = w.gap_after;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver: stall drawn per word, long hold at two points
  always @(negedge clk) begin : drive_stall
    if (rsp_taken) begin
      if (replies_seen % 150 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
      if (replies_seen == 400 || replies_seen == 1100) rx_wait = 300;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : watch_ports
    reply_t want;
    bit     req_fire;
    bit     rsp_fire;
    req_fire = req_valid && !req_stall;
    rsp_fire = rsp_valid && !rsp_stall;
    req_taken <= req_fire;
    rsp_taken <= rsp_fire;
    if (!rst) begin
      if (req_fire) expected_replies.push_back(list_apply(func, key_value, link_value));
      if (rsp_fire) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          $error("response word with no request pending");
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (entry_total !== want.total) begin
            $error("entry_total: expected %0d, got %0d", want.total, entry_total);
            fail_count++;
          end
        end
      end
      if (req_fire || rsp_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[ordered_key_list_engine] ERROR");
        $finish;
      end
    end
  end

  initial begin : run_test
    logic [31:0] key_pool[8];
    logic [31:0] k;
    logic [1:0]  op;
    int          append_weight;
    int          n;
    int          j;

    // empty list, then fill to the brim with edge and random keys and append once more
    queue_word(FN_SEARCH, 32'h0000_0000, 32'h0, 0);
    queue_word(FN_REMOVE, 32'hffff_ffff, 32'h0, 0);
    queue_word(FN_POP, 32'h8000_0000, 32'h0, 0);
    queue_word(FN_APPEND, 32'h8000_0000, 32'h7fff_ffff, 0);
    queue_word(FN_APPEND, 32'h7fff_ffff, 32'h8000_0000, 0);
    queue_word(FN_APPEND, 32'h0000_0000, 32'hffff_ffff, 0);
    queue_word(FN_APPEND, 32'hffff_ffff, 32'h0000_0000, 0);
    queue_word(FN_APPEND, 32'h8000_0000, 32'h5555_5555, 0);
    queue_word(FN_APPEND, 32'h5555_5555, 32'haaaa_aaaa, 0);
    queue_word(FN_APPEND, 32'haaaa_aaaa, 32'h5555_5555, 0);
    for (n = 7; n < DEPTH_DEF; n++)
      queue_word(FN_APPEND, (n % 3 == 0) ? 32'h8000_0000 : $urandom, $urandom, 0);
    queue_word(FN_APPEND, 32'h1234_5678, 32'h1, 0);
    queue_word(FN_SEARCH, 32'h7fff_ffff, 32'h0, 0);
    queue_word(FN_SEARCH, 32'h1234_5678, 32'h0, 0);
    queue_word(FN_REMOVE, 32'h8000_0000, 32'h0, 0);
    queue_word(FN_REMOVE, 32'h8000_0000, 32'h0, 0);
    queue_word(FN_POP, 32'h0, 32'h0, 0);

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    append_weight = 50;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: append_weight = 20;
          1: append_weight = 50;
          default: append_weight = 85;
        endcase
        tx_burst = ($urandom_range(0, 3) == 0);
        for (j = 4; j < 8; j++) key_pool[j] = $urandom;
      end
      if ($urandom_range(0, 99) < append_weight) op = FN_APPEND;
      else op = 2'($urandom_range(1, 3));
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)] : $urandom;
      queue_word(op, k, $urandom, (n == 600) || ($urandom_range(0, 149) == 0));
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_queue.size() > 0 || req_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ordered_key_list_engine] OK");
    end else begin
      $display("[ordered_key_list_engine] ERROR");
    end
    $finish;
  end

endmodule
